[rtl/core/gtp_pkg.sv]
// Shared types and constants for the Goertzel tone power block.
package gtp_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int BLEN_W    = 12;
  localparam int POWER_W   = 32;
  localparam int MOPB_W    = 18;   // wide multiplier operand: (q*c)>>>14
  localparam int PROD_W    = 32;   // low product bits kept; power math wraps at 32
  localparam int FRAC_BITS = 14;
  localparam int PWR_DOWN  = 15;
  localparam int PWR_UP    = 8;

  localparam logic [COEF_W-1:0] COEF_RESET = '0;
  localparam logic [BLEN_W-1:0] BLEN_RESET = 12'd206;

  // register word index (paddr[2])
  localparam logic REG_COEF = 1'b0;
  localparam logic REG_BLEN = 1'b1;

  typedef struct packed {
    logic signed [COEF_W-1:0] coefficient;
    logic        [BLEN_W-1:0] block_length;
  } gtp_cfg_t;

endpackage

[rtl/core/gtp_cfg_regs.sv]
// APB register file holding the coefficient and the block length.
module gtp_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output gtp_pkg::gtp_cfg_t   cfg
);
  import gtp_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coefficient  <= COEF_RESET;
      cfg.block_length <= BLEN_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_COEF: cfg.coefficient  <= pwdata[COEF_W-1:0];
        REG_BLEN: cfg.block_length <= pwdata[BLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_COEF: prdata = {{(32-COEF_W){cfg.coefficient[COEF_W-1]}}, cfg.coefficient};
      REG_BLEN: prdata = {{(32-BLEN_W){1'b0}}, cfg.block_length};
      default:  prdata = '0;
    endcase
  end

endmodule

[rtl/core/gtp_mul.sv]
// Shared signed multiplier with a registered product (low 32 bits).
module gtp_mul (
  input  logic                                   clk,
  input  logic signed [gtp_pkg::SAMPLE_W-1:0]    op_a,
  input  logic signed [gtp_pkg::MOPB_W-1:0]      op_b,
  output logic        [gtp_pkg::PROD_W-1:0]      prod
);
  import gtp_pkg::*;

  logic signed [SAMPLE_W+MOPB_W-1:0] full;

  assign full = op_a * op_b;

  always_ff @(posedge clk) begin
    prod <= full[PROD_W-1:0];
  end

endmodule

[rtl/core/goertzel_tone_power.sv]
// Goertzel tone power detector: sequencer and datapath around one shared multiplier.
//
// Usage:
//   Samples enter on s_axis (tdata = sample_in, signed 16 bit). Each sample
//   runs s = x + ((coef*s1)>>>14) - s2 on the shared multiplier.
//   A sample goes through accept, multiply and state update; s_axis_tready
//   is low from an accept until the sequencer is back in idle.
//   On the sample that brings the count to block_length the sequencer runs
//   the power formula on the same multiplier. tone_power is then presented
//   on m_axis, and the recursion state and counter are cleared at that point.
//   The output register holds one result; if the receiver stalls, the block
//   still takes samples until the next result is due, then waits for the
//   pending one to be taken.
//   The shared multiplier gives one product a cycle.
//   Registers (APB): coefficient at 0x0, block_length at 0x4; write them
//   only while idle.
//   Reset clears state, counter and output valid; coefficient resets to 0
//   and block_length to 206.
module goertzel_tone_power (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // sample input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample_in
  // power output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] tone_power
);
  import gtp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_S, ST_UPD,
    ST_PW_PP, ST_PW_QQ, ST_PW_QC, ST_PW_M, ST_PW_PM, ST_PW_SUB, ST_PW_OUT
  } state_t;

  state_t                     state;
  gtp_cfg_t                   cfg;
  logic signed [SAMPLE_W-1:0] x_in;
  logic signed [SAMPLE_W-1:0] prev_state;
  logic signed [SAMPLE_W-1:0] prev_prev_state;
  logic        [BLEN_W-1:0]   sample_count;
  logic        [BLEN_W-1:0]   count_next;
  logic signed [MOPB_W-1:0]   mreg;
  logic        [PROD_W-1:0]   acc;
  logic        [PROD_W-1:0]   prod;
  logic signed [SAMPLE_W-1:0] op_a;
  logic signed [MOPB_W-1:0]   op_b;
  logic        [SAMPLE_W-1:0] s_next;
  logic signed [POWER_W-1:0]  pw_shr;
  logic        [POWER_W-1:0]  pw_out;

  gtp_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gtp_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign count_next    = sample_count + 1'b1;
  // wraps at 16 bits; only the low bits of the shifted product matter
  assign s_next = x_in + prod[FRAC_BITS +: SAMPLE_W] - prev_prev_state;
  assign pw_shr = $signed(acc) >>> PWR_DOWN;
  assign pw_out = pw_shr << PWR_UP;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      ST_MUL_S: begin
        op_a = cfg.coefficient;
        op_b = MOPB_W'(prev_state);
      end
      ST_PW_PP: begin
        op_a = prev_state;
        op_b = MOPB_W'(prev_state);
      end
      ST_PW_QQ: begin
        op_a = prev_prev_state;
        op_b = MOPB_W'(prev_prev_state);
      end
      ST_PW_QC: begin
        op_a = prev_prev_state;
        op_b = MOPB_W'(cfg.coefficient);
      end
      ST_PW_PM: begin
        op_a = prev_state;
        op_b = mreg;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      prev_state      <= '0;
      prev_prev_state <= '0;
      sample_count    <= '0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      // ST_PW_OUT drives valid itself
      if (m_axis_tvalid && m_axis_tready && state != ST_PW_OUT) m_axis_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            x_in  <= s_axis_tdata;
            state <= ST_MUL_S;
          end
        end
        ST_MUL_S: state <= ST_UPD;
        ST_UPD: begin
          prev_prev_state <= prev_state;
          prev_state      <= s_next;
          sample_count    <= count_next;
          state <= (count_next == cfg.block_length) ? ST_PW_PP : ST_IDLE;
        end
        ST_PW_PP: state <= ST_PW_QQ;
        ST_PW_QQ: begin
          acc   <= prod;                 // p*p
          state <= ST_PW_QC;
        end
        ST_PW_QC: begin
          acc   <= acc + prod;           // + q*q
          state <= ST_PW_M;
        end
        ST_PW_M: begin
          mreg  <= prod[FRAC_BITS +: MOPB_W];  // (q*c)>>>14
          state <= ST_PW_PM;
        end
        ST_PW_PM: state <= ST_PW_SUB;
        ST_PW_SUB: begin
          acc   <= acc - prod;           // - p*m
          state <= ST_PW_OUT;
        end
        ST_PW_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata    <= pw_out;
            m_axis_tvalid   <= 1'b1;
            prev_state      <= '0;
            prev_prev_state <= '0;
            sample_count    <= '0;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("sample accepted while previous still in work");

  a_clear_on_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> (prev_state == '0 && prev_prev_state == '0 &&
                              sample_count == '0))
    else $error("state not cleared when power emitted");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PW_OUT && m_axis_tvalid && !m_axis_tready) |=> state == ST_PW_OUT)
    else $error("pending result overwritten");
`endif

endmodule
